FILE: hw/rtl/lct_pkg.sv
// ---------------------------------------------------------------------------
// lct_pkg: shared definitions for the torus cluster search
// Grid geometry, counter widths, register indexes, cell and queue entry types.
// ---------------------------------------------------------------------------
package lct_pkg;

	localparam int MAX_SIDE   = 64;
	localparam int CELLS      = MAX_SIDE * MAX_SIDE;
	localparam int COORD_W    = $clog2(MAX_SIDE);
	localparam int IDX_W      = $clog2(CELLS);
	localparam int CNT_W      = $clog2(CELLS + 1);
	localparam int SEFF_W     = $clog2(MAX_SIDE + 1);
	localparam int SIDE_W     = 7;
	localparam int SIZE_W     = 13;
	localparam int SIZE_LIMIT = 8191;
	localparam int CFG_W      = 7;
	localparam int REG_IDX_W  = 1;

	localparam logic [REG_IDX_W-1:0] REG_GRID_SIDE   = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_TARGET_SPIN = REG_IDX_W'(1);

	typedef logic [SEFF_W-1:0] side_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [IDX_W-1:0]  idx_t;

	typedef enum logic [1:0] {
		DIR_LEFT,
		DIR_RIGHT,
		DIR_UP,
		DIR_DOWN
	} dir_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} coord_t;

	typedef struct packed {
		logic visited;
		logic spin;
	} cell_t;

	// zero counts as one, anything above the array size saturates
	function automatic side_t side_in_force(input logic [SIDE_W-1:0] s);
		if (s == '0) begin
			return SEFF_W'(1);
		end
		if (int'(s) > MAX_SIDE) begin
			return SEFF_W'(MAX_SIDE);
		end
		return SEFF_W'(s);
	endfunction

	function automatic count_t cell_count(input side_t s);
		return CNT_W'(s) * CNT_W'(s);
	endfunction

endpackage

FILE: hw/rtl/lct_spin_if.sv
// ---------------------------------------------------------------------------
// lct_spin_if: spin input channel
// Valid/ready channel carrying one cell spin per request.
// ---------------------------------------------------------------------------
interface lct_spin_if;
	logic valid;
	logic ready;
	logic spin_up;

	modport source (output valid, output spin_up, input ready);
	modport sink   (input valid, input spin_up, output ready);
endinterface

FILE: hw/rtl/lct_size_if.sv
// ---------------------------------------------------------------------------
// lct_size_if: cluster size result channel
// Valid/ready channel carrying the size of the largest cluster of a grid.
// ---------------------------------------------------------------------------
interface lct_size_if;
	logic                        valid;
	logic                        ready;
	logic [lct_pkg::SIZE_W-1:0]  largest_size;

	modport source (output valid, output largest_size, input ready);
	modport sink   (input valid, input largest_size, output ready);
endinterface

FILE: hw/rtl/lct_ram.sv
// ---------------------------------------------------------------------------
// lct_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module lct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/lct_nbr.sv
// ---------------------------------------------------------------------------
// lct_nbr: neighbour address unit
// Steps one cell in a given direction with wrap at every edge and forms
// the row-major index of the neighbour.
// ---------------------------------------------------------------------------
module lct_nbr (
	input  lct_pkg::coord_t cur,
	input  lct_pkg::dir_t   dir,
	input  lct_pkg::side_t  side,
	output lct_pkg::coord_t nbr,
	output lct_pkg::idx_t   idx
);
	import lct_pkg::*;

	logic [COORD_W-1:0] last;

	assign last = COORD_W'(side - SEFF_W'(1));

	always_comb begin
		nbr = cur;
		case (dir)
			DIR_LEFT: begin
				nbr.col = (cur.col == '0) ? last : cur.col - COORD_W'(1);
			end
			DIR_RIGHT: begin
				nbr.col = (cur.col == last) ? '0 : cur.col + COORD_W'(1);
			end
			DIR_UP: begin
				nbr.row = (cur.row == '0) ? last : cur.row - COORD_W'(1);
			end
			DIR_DOWN: begin
				nbr.row = (cur.row == last) ? '0 : cur.row + COORD_W'(1);
			end
			default: begin
				nbr = cur;
			end
		endcase
	end

	assign idx = IDX_W'(CNT_W'(nbr.row) * CNT_W'(side) + CNT_W'(nbr.col));

endmodule

FILE: hw/rtl/largest_cluster_on_torus_unit.sv
// ---------------------------------------------------------------------------
// largest_cluster_on_torus_unit: largest same-spin cluster on a wrapped grid
// Spins arrive one per request in row-major order, one per cycle while the
// unit loads. The request that completes a grid (side*side cells, side taken
// from grid_side at each request) starts a breadth-first search over four
// neighbours with wrap at all edges, and the unit takes no spins until it is
// over. The search reads and checks each cell in scan order; each cell
// of the target spin is popped from the queue (pop, then a wait for the
// queue read) and its four neighbours are looked at one by one, each with
// an address step and a check step, through the single neighbour address
// unit and the one read port of the cell memory. Last the result is handed
// over. The visited flag lives beside each spin and is cleared as the spin
// is loaded, so there is no clearing pass after reset or between grids. A
// finished result waits in the output register while the next grid loads.
// ---------------------------------------------------------------------------
module largest_cluster_on_torus_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lct_pkg::REG_IDX_W-1:0]  cfg_idx,
	input  logic [lct_pkg::CFG_W-1:0]      cfg_wdata,
	lct_spin_if.sink                       spin,
	lct_size_if.source                     result
);
	import lct_pkg::*;

	typedef enum logic [2:0] {
		S_LOAD,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_POP,
		S_POP_WAIT,
		S_NB_ADDR,
		S_NB_CHK,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [SIDE_W-1:0]   side_cfg_q;
	logic                target_cfg_q;
	idx_t                loaded_q;
	side_t               side_q;
	count_t              total_q;
	logic                want_q;
	coord_t              scan_q;
	idx_t                scan_i_q;
	count_t              head_q;
	count_t              tail_q;
	count_t              size_q;
	count_t              best_q;
	coord_t              cur_q;
	coord_t              nb_q;
	idx_t                nidx_q;
	dir_t                dir_q;
	logic                res_valid_q;
	logic [SIZE_W-1:0]   res_size_q;

	side_t               side_now;
	count_t              total_now;
	logic                in_acc;
	logic                grid_full;
	logic                cell_hit;
	logic                scan_last;
	logic [COORD_W-1:0]  side_last;
	coord_t              scan_next;
	coord_t              nbr_c;
	idx_t                nidx_c;
	count_t              tail_after;
	count_t              new_best;
	logic                out_free;
	logic [SIZE_W-1:0]   best_sat;

	logic                cell_we;
	idx_t                cell_waddr;
	cell_t               cell_wdata;
	idx_t                cell_raddr;
	cell_t               cell_rdata;
	logic                q_we;
	idx_t                q_waddr;
	coord_t              q_wdata;
	coord_t              q_rdata;

	assign side_now   = side_in_force(side_cfg_q);
	assign total_now  = cell_count(side_now);
	assign spin.ready = (state_q == S_LOAD);
	assign in_acc     = spin.valid && spin.ready;
	assign grid_full  = (CNT_W'(loaded_q) + CNT_W'(1)) >= total_now;

	assign cell_hit   = (cell_rdata.spin == want_q) && !cell_rdata.visited;
	assign scan_last  = (CNT_W'(scan_i_q) == total_q - CNT_W'(1));
	assign side_last  = COORD_W'(side_q - SEFF_W'(1));
	assign tail_after = cell_hit ? tail_q + CNT_W'(1) : tail_q;
	assign new_best   = (size_q > best_q) ? size_q : best_q;
	assign out_free   = !res_valid_q || result.ready;
	assign best_sat   = (32'(best_q) > SIZE_LIMIT) ? SIZE_W'(SIZE_LIMIT) : SIZE_W'(best_q);

	always_comb begin
		scan_next = scan_q;
		if (scan_q.col == side_last) begin
			scan_next.col = '0;
			scan_next.row = scan_q.row + COORD_W'(1);
		end else begin
			scan_next.col = scan_q.col + COORD_W'(1);
		end
	end

	lct_nbr u_nbr (
		.cur  (cur_q),
		.dir  (dir_q),
		.side (side_q),
		.nbr  (nbr_c),
		.idx  (nidx_c)
	);

	// memory port steering
	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = loaded_q;
		cell_wdata = '{visited: 1'b0, spin: spin.spin_up};
		cell_raddr = scan_i_q;
		q_we       = 1'b0;
		q_waddr    = tail_q[IDX_W-1:0];
		q_wdata    = nb_q;
		case (state_q)
			S_LOAD: begin
				cell_we = in_acc;
			end
			S_SCAN_CHK: begin
				cell_we    = cell_hit;
				cell_waddr = scan_i_q;
				cell_wdata = '{visited: 1'b1, spin: want_q};
				q_we       = cell_hit;
				q_waddr    = '0;
				q_wdata    = scan_q;
			end
			S_NB_ADDR: begin
				cell_raddr = nidx_c;
			end
			S_NB_CHK: begin
				cell_we    = cell_hit;
				cell_waddr = nidx_q;
				cell_wdata = '{visited: 1'b1, spin: want_q};
				q_we       = cell_hit;
			end
			default: begin
				cell_we = 1'b0;
			end
		endcase
	end

	lct_ram #(
		.WIDTH ($bits(cell_t)),
		.DEPTH (CELLS)
	) u_cell_mem (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	lct_ram #(
		.WIDTH ($bits(coord_t)),
		.DEPTH (CELLS)
	) u_queue_mem (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (head_q[IDX_W-1:0]),
		.rdata (q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			side_cfg_q   <= SIDE_W'(64);
			target_cfg_q <= 1'b0;
			loaded_q     <= '0;
			side_q       <= SEFF_W'(1);
			total_q      <= CNT_W'(1);
			want_q       <= 1'b0;
			scan_q       <= '0;
			scan_i_q     <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			size_q       <= '0;
			best_q       <= '0;
			dir_q        <= DIR_LEFT;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == REG_GRID_SIDE) begin
				side_cfg_q <= cfg_wdata[SIDE_W-1:0];
			end
			if (cfg_we && cfg_idx == REG_TARGET_SPIN) begin
				target_cfg_q <= cfg_wdata[0];
			end
			if (state_q == S_DONE && out_free) begin
				res_valid_q <= 1'b1;
				res_size_q  <= best_sat;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (grid_full) begin
							side_q   <= side_now;
							total_q  <= total_now;
							want_q   <= target_cfg_q;
							scan_q   <= '0;
							scan_i_q <= '0;
							best_q   <= '0;
							loaded_q <= '0;
							state_q  <= S_SCAN_RD;
						end else begin
							loaded_q <= loaded_q + IDX_W'(1);
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (cell_hit) begin
						// seed a new cluster
						head_q  <= '0;
						tail_q  <= CNT_W'(1);
						size_q  <= '0;
						state_q <= S_POP;
					end else if (scan_last) begin
						state_q <= S_DONE;
					end else begin
						scan_q   <= scan_next;
						scan_i_q <= scan_i_q + IDX_W'(1);
						state_q  <= S_SCAN_RD;
					end
				end
				S_POP: begin
					head_q  <= head_q + CNT_W'(1);
					state_q <= S_POP_WAIT;
				end
				S_POP_WAIT: begin
					cur_q   <= q_rdata;
					size_q  <= size_q + CNT_W'(1);
					dir_q   <= DIR_LEFT;
					state_q <= S_NB_ADDR;
				end
				S_NB_ADDR: begin
					nb_q    <= nbr_c;
					nidx_q  <= nidx_c;
					state_q <= S_NB_CHK;
				end
				S_NB_CHK: begin
					tail_q <= tail_after;
					if (dir_q != DIR_DOWN) begin
						dir_q   <= dir_t'(dir_q + 2'd1);
						state_q <= S_NB_ADDR;
					end else if (head_q != tail_after) begin
						state_q <= S_POP;
					end else begin
						// queue drained, cluster complete
						best_q <= new_best;
						if (scan_last) begin
							state_q <= S_DONE;
						end else begin
							scan_q   <= scan_next;
							scan_i_q <= scan_i_q + IDX_W'(1);
							state_q  <= S_SCAN_RD;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign result.valid        = res_valid_q;
	assign result.largest_size = res_size_q;

endmodule

FILE: hw/rtl/lct_checker.sv
// ---------------------------------------------------------------------------
// lct_checker: port-level checks for the torus cluster unit
// Watches the spin and result channels and is bound to the top level.
// ---------------------------------------------------------------------------
module lct_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        spin_valid,
	input  logic                        spin_ready,
	input  logic                        res_valid,
	input  logic                        res_ready,
	input  logic [lct_pkg::SIZE_W-1:0]  res_size
);
	import lct_pkg::*;

	// a stalled result holds its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_size))
		else $error("result changed while stalled");

	// the unit stops taking spins only after a request has been taken
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(spin_ready) |-> $past(spin_valid))
		else $error("spin ready dropped without a request");

	// a result is only produced out of the search, never while loading
	a_res_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!spin_ready))
		else $error("result appeared while loading");

	// no cluster is larger than the grid
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(res_size) <= CELLS)
		else $error("cluster size exceeds grid");

endmodule

bind largest_cluster_on_torus_unit lct_checker u_lct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.spin_valid (spin.valid),
	.spin_ready (spin.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_size   (result.largest_size)
);
